// ===== design/srtn_pkg.sv =====
// shared types and constants for the srtn scheduler
package srtn_pkg;

  localparam int DEF_NUM_JOBS  = 32;
  localparam int DEF_TIME_BITS = 16;

  localparam int JOB_ID_W   = 5;
  localparam int SVC_W      = 16;
  localparam int SHOWN_W    = 16;
  localparam int CLOCK_W    = 32;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_DISPATCH,
    S_PUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic scan_clr;
    logic scan_rd;
    logic dispatch;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_scan;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/srtn_ram.sv =====
// generic single-port-write ram with registered read
module srtn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/srtn_ctrl.sv =====
// controller state machine for the srtn scheduler
module srtn_ctrl
  import srtn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.go_scan) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // last read word is compared here
      S_DRAIN: begin
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        state_next   = S_PUSH;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/srtn_dp.sv =====
// datapath: cpu state, ready table, min scan and output register
module srtn_dp
  import srtn_pkg::*;
#(
  parameter int NUM_JOBS  = DEF_NUM_JOBS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                s_tuser,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = $clog2(NUM_JOBS);
  localparam int CNT_W = $clog2(NUM_JOBS + 1);
  localparam logic [CLOCK_W-1:0] TIME_MASK = CLOCK_W'((64'd1 << TIME_BITS) - 64'd1);

  // latched input word
  logic                in_mode;
  logic [JOB_ID_W-1:0] in_jid;
  logic [SVC_W-1:0]    in_svc;

  // cpu state
  logic                 busy;
  logic [IDX_W-1:0]     cur_job;
  logic [TIME_BITS-1:0] cur_rem;
  logic [CLOCK_W-1:0]   time_now;

  // ready table bookkeeping
  logic [NUM_JOBS-1:0]  vld;
  logic [CNT_W-1:0]     cnt;

  // scan
  logic [IDX_W-1:0]     scan_idx;
  logic                 cmp_en;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS-1:0] best_rem;
  logic [TIME_BITS-1:0] ram_q;
  logic [TIME_BITS-1:0] cand;

  logic [M_DATA_W-1:0]  res;
  logic [M_DATA_W-1:0]  res_next;

  // exec logic
  logic [TIME_BITS-1:0] svc_sat;
  logic [IDX_W-1:0]     jid_idx;
  logic                 arr_ok;
  logic                 preempt;
  logic                 park;
  logic                 finish;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [TIME_BITS-1:0] wr_data;
  logic                 busy_next;
  logic [IDX_W-1:0]     job_next;
  logic [TIME_BITS-1:0] rem_next;
  logic [CLOCK_W-1:0]   time_next;

  logic                 r_busy;
  logic [JOB_ID_W-1:0]  r_job;
  logic [SHOWN_W-1:0]   r_rem;
  logic                 r_pre;
  logic                 r_fin;
  logic [JOB_ID_W-1:0]  r_fjob;
  logic [CLOCK_W-1:0]   r_dep;
  logic                 r_empty;

  always_comb begin
    if (CLOCK_W'(in_svc) > TIME_MASK) begin
      svc_sat = '1;
    end else begin
      svc_sat = TIME_BITS'(CLOCK_W'(in_svc));
    end
  end

  assign jid_idx = IDX_W'(in_jid);
  assign arr_ok  = (CLOCK_W'(in_jid) < CLOCK_W'(NUM_JOBS)) && (svc_sat != '0);
  assign preempt = !in_mode && arr_ok && busy && (svc_sat < cur_rem);
  assign park    = !in_mode && arr_ok && busy && !preempt;
  assign finish  = busy && (cur_rem <= TIME_BITS'(1));
  assign wr_en   = cmd.exec && (preempt || park);
  assign wr_addr = preempt ? cur_job : jid_idx;
  assign wr_data = preempt ? cur_rem : svc_sat;

  always_comb begin
    busy_next = busy;
    job_next  = cur_job;
    rem_next  = cur_rem;
    time_next = time_now;
    r_pre     = 1'b0;
    r_fin     = 1'b0;
    r_fjob    = '0;
    r_dep     = '0;
    if (!in_mode) begin
      if ((arr_ok && !busy) || preempt) begin
        busy_next = 1'b1;
        job_next  = jid_idx;
        rem_next  = svc_sat;
      end
      r_pre   = preempt;
      r_busy  = busy_next;
      r_job   = busy_next ? JOB_ID_W'(job_next) : '0;
      r_rem   = busy_next ? SHOWN_W'(rem_next) : '0;
      r_empty = (cnt == '0) && !(preempt || park);
    end else begin
      time_next = time_now + CLOCK_W'(1);
      if (busy) begin
        if (finish) begin
          busy_next = 1'b0;
          rem_next  = '0;
          r_fin     = 1'b1;
          r_fjob    = JOB_ID_W'(cur_job);
          r_dep     = time_now + CLOCK_W'(1);
        end else begin
          rem_next = cur_rem - TIME_BITS'(1);
        end
      end
      r_busy  = busy;
      r_job   = busy ? JOB_ID_W'(cur_job) : '0;
      r_rem   = busy ? SHOWN_W'(cur_rem) : '0;
      r_empty = (cnt == '0);
    end
    res_next = {2'b00, r_empty, r_dep, r_fjob, r_fin, r_pre, r_rem, r_job, r_busy};
  end

  assign sts.go_scan   = in_mode && finish && (cnt != '0);
  assign sts.scan_last = (scan_idx == IDX_W'(NUM_JOBS - 1));
  assign sts.out_free  = !m_tvalid || m_tready;

  assign cand = cmp_vld ? ram_q : '0;

  srtn_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(NUM_JOBS)
  ) u_ready_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(scan_idx),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_mode <= s_tuser;
      in_jid  <= s_tdata[JOB_ID_W-1:0];
      in_svc  <= s_tdata[JOB_ID_W+SVC_W-1:JOB_ID_W];
    end
    if (cmd.exec) begin
      res <= res_next;
    end
    cmp_idx <= scan_idx;
    if (cmd.scan_clr) begin
      best_idx <= '0;
    end else if (cmp_en && cand != '0 && (best_rem == '0 || cand < best_rem)) begin
      best_idx <= cmp_idx;
    end
    if (cmd.push) begin
      m_tdata <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cur_job  <= '0;
      cur_rem  <= '0;
      time_now <= '0;
      vld      <= '0;
      cnt      <= '0;
      scan_idx <= '0;
      cmp_en   <= 1'b0;
      cmp_vld  <= 1'b0;
      best_rem <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        busy     <= busy_next;
        cur_job  <= job_next;
        cur_rem  <= rem_next;
        time_now <= time_next;
        if (wr_en) begin
          vld[wr_addr] <= 1'b1;
          if (!vld[wr_addr]) begin
            cnt <= cnt + CNT_W'(1);
          end
        end
      end else if (cmd.dispatch) begin
        busy          <= 1'b1;
        cur_job       <= best_idx;
        cur_rem       <= best_rem;
        vld[best_idx] <= 1'b0;
        cnt           <= cnt - CNT_W'(1);
      end

      cmp_en  <= cmd.scan_rd;
      cmp_vld <= cmd.scan_rd ? vld[scan_idx] : 1'b0;
      if (cmd.scan_clr) begin
        scan_idx <= '0;
        best_rem <= '0;
      end else begin
        if (cmd.scan_rd) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        // strict less keeps the lowest id on ties
        if (cmp_en && cand != '0 && (best_rem == '0 || cand < best_rem)) begin
          best_rem <= cand;
        end
      end

      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_cnt_matches_flags: assert property (@(posedge clk) disable iff (rst)
    cnt == CNT_W'($countones(vld)))
    else $error("ready count out of step with valid flags");

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> cur_rem != '0)
    else $error("busy cpu with zero remaining time");

  a_dispatch_found: assert property (@(posedge clk) disable iff (rst)
    cmd.dispatch |-> best_rem != '0)
    else $error("dispatch without a waiting job");

  a_dispatch_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.dispatch |=> !vld[$past(best_idx)])
    else $error("dispatched entry still marked waiting");

endmodule

// ===== design/srtn_preemptive_scheduler.sv =====
// top level of the preemptive shortest-remaining-time-next scheduler
// Each input word is a job arrival (tuser 0) or a tick (tuser 1) and yields one
// result word. Words are taken one at a time: an arrival, or a tick that does
// not dispatch a waiting job, goes from accept through the exec state to the
// push state and back to idle; a tick that finishes the running job while jobs
// wait also runs the scan, drain and dispatch states, a linear minimum search
// that reads the ready table through the one read port of its ram, one entry
// per cycle. A held output stalls the word in the push state before the output
// register loads. A new word is accepted while the previous result is still
// held on the output. The ready table's empty state comes from per-entry flags
// cleared by reset, so the block is usable in the first cycle after reset.
module srtn_preemptive_scheduler
  import srtn_pkg::*;
#(
  parameter int NUM_JOBS  = DEF_NUM_JOBS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // job_id[4:0], service_time[20:5], zero pad
  input  logic                s_tuser,  // mode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // cpu_busy[0], running_job[5:1],
                                        // shown_remaining[21:6], preempted[22],
                                        // job_finished[23], finished_job[28:24],
                                        // departure_time[60:29], ready_empty[61]
);

  cmd_t cmd;
  sts_t sts;

  srtn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  srtn_dp #(
    .NUM_JOBS (NUM_JOBS),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule
